// ===== hdl/snow3g_pkg.sv =====
package snow3g_pkg;

    // Longest keystream burst of one generate transaction
    localparam int MAX_BURST   = 64;
    localparam int INIT_ROUNDS = 32;
    localparam int WC_W        = 7;
    localparam int CNT_W       =
        $clog2(((MAX_BURST > INIT_ROUNDS) ? MAX_BURST : INIT_ROUNDS) + 1);

    localparam logic MODE_INIT = 1'b0;
    localparam logic MODE_GEN  = 1'b1;

    localparam logic [7:0] POLY_ALPHA = 8'ha9;
    localparam logic [7:0] POLY_S1    = 8'h1b;
    localparam logic [7:0] POLY_S2    = 8'h69;

    typedef struct packed {
        logic [15:0][31:0] lfsr;
        logic [31:0]       r1;
        logic [31:0]       r2;
        logic [31:0]       r3;
    } cipher_state_t;

    typedef struct packed {
        logic load_init;
        logic step;
        logic feed_fsm;
        logic emit;
        logic last;
    } ctrl_t;

    localparam logic [7:0] SBOX_R [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] SBOX_Q [256] = '{
        8'h25,8'h24,8'h73,8'h67,8'hD7,8'hAE,8'h5C,8'h30,8'hA4,8'hEE,8'h6E,8'hCB,8'h7D,8'hB5,8'h82,8'hDB,
        8'hE4,8'h8E,8'h48,8'h49,8'h4F,8'h5D,8'h6A,8'h78,8'h70,8'h88,8'hE8,8'h5F,8'h5E,8'h84,8'h65,8'hE2,
        8'hD8,8'hE9,8'hCC,8'hED,8'h40,8'h2F,8'h11,8'h28,8'h57,8'hD2,8'hAC,8'hE3,8'h4A,8'h15,8'h1B,8'hB9,
        8'hB2,8'h80,8'h85,8'hA6,8'h2E,8'h02,8'h47,8'h29,8'h07,8'h4B,8'h0E,8'hC1,8'h51,8'hAA,8'h89,8'hD4,
        8'hCA,8'h01,8'h46,8'hB3,8'hEF,8'hDD,8'h44,8'h7B,8'hC2,8'h7F,8'hBE,8'hC3,8'h9F,8'h20,8'h4C,8'h64,
        8'h83,8'hA2,8'h68,8'h42,8'h13,8'hB4,8'h41,8'hCD,8'hBA,8'hC6,8'hBB,8'h6D,8'h4D,8'h71,8'h21,8'hF4,
        8'h8D,8'hB0,8'hE5,8'h93,8'hFE,8'h8F,8'hE6,8'hCF,8'h43,8'h45,8'h31,8'h22,8'h37,8'h36,8'h96,8'hFA,
        8'hBC,8'h0F,8'h08,8'h52,8'h1D,8'h55,8'h1A,8'hC5,8'h4E,8'h23,8'h69,8'h7A,8'h92,8'hFF,8'h5B,8'h5A,
        8'hEB,8'h9A,8'h1C,8'hA9,8'hD1,8'h7E,8'h0D,8'hFC,8'h50,8'h8A,8'hB6,8'h62,8'hF5,8'h0A,8'hF8,8'hDC,
        8'h03,8'h3C,8'h0C,8'h39,8'hF1,8'hB8,8'hF3,8'h3D,8'hF2,8'hD5,8'h97,8'h66,8'h81,8'h32,8'hA0,8'h00,
        8'h06,8'hCE,8'hF6,8'hEA,8'hB7,8'h17,8'hF7,8'h8C,8'h79,8'hD6,8'hA7,8'hBF,8'h8B,8'h3F,8'h1F,8'h53,
        8'h63,8'h75,8'h35,8'h2C,8'h60,8'hFD,8'h27,8'hD3,8'h94,8'hA5,8'h7C,8'hA1,8'h05,8'h58,8'h2D,8'hBD,
        8'hD9,8'hC7,8'hAF,8'h6B,8'h54,8'h0B,8'hE0,8'h38,8'h04,8'hC8,8'h9D,8'hE7,8'h14,8'hB1,8'h87,8'h9C,
        8'hDF,8'h6F,8'hF9,8'hDA,8'h2A,8'hC4,8'h59,8'h16,8'h74,8'h91,8'hAB,8'h26,8'h61,8'h76,8'h34,8'h2B,
        8'hAD,8'h99,8'hFB,8'h72,8'hEC,8'h33,8'h12,8'hDE,8'h98,8'h3B,8'hC0,8'h9B,8'h3E,8'h18,8'h10,8'h3A,
        8'h56,8'hE1,8'h77,8'hC9,8'h1E,8'h9E,8'h95,8'hA3,8'h90,8'h19,8'hA8,8'h6C,8'h09,8'hD0,8'hF0,8'h86
    };

    function automatic logic [7:0] times_x(input logic [7:0] v, input logic [7:0] poly);
        return {v[6:0], 1'b0} ^ (v[7] ? poly : 8'h00);
    endfunction

    // Elaboration only: repeated multiply by x in GF(2^8)
    function automatic logic [7:0] times_x_pow(input logic [7:0] v, input int n);
        logic [7:0] r;
        r = v;
        for (int i = 0; i < n; i++) begin
            r = times_x(r, POLY_ALPHA);
        end
        return r;
    endfunction

    function automatic logic [31:0] mul_basis(input int b);
        logic [7:0] c;
        c = 8'(1 << b);
        return {times_x_pow(c, 23), times_x_pow(c, 245), times_x_pow(c, 48),
                times_x_pow(c, 239)};
    endfunction

    function automatic logic [31:0] div_basis(input int b);
        logic [7:0] c;
        c = 8'(1 << b);
        return {times_x_pow(c, 16), times_x_pow(c, 39), times_x_pow(c, 6),
                times_x_pow(c, 64)};
    endfunction

    // Both maps are linear over GF(2): one constant word per input bit
    localparam logic [7:0][31:0] MUL_BASIS = {
        mul_basis(7), mul_basis(6), mul_basis(5), mul_basis(4),
        mul_basis(3), mul_basis(2), mul_basis(1), mul_basis(0)
    };

    localparam logic [7:0][31:0] DIV_BASIS = {
        div_basis(7), div_basis(6), div_basis(5), div_basis(4),
        div_basis(3), div_basis(2), div_basis(1), div_basis(0)
    };

    function automatic logic [31:0] mul_alpha(input logic [7:0] c);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) begin
                r = r ^ MUL_BASIS[i];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] div_alpha(input logic [7:0] c);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) begin
                r = r ^ DIV_BASIS[i];
            end
        end
        return r;
    endfunction

    // Column mix of four substituted bytes
    function automatic logic [31:0] mix_column(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic [7:0] d,
                                               input logic [7:0] poly);
        logic [7:0] xa;
        logic [7:0] xb;
        logic [7:0] xc;
        logic [7:0] xd;
        xa = times_x(a, poly);
        xb = times_x(b, poly);
        xc = times_x(c, poly);
        xd = times_x(d, poly);
        return {xa ^ b ^ c ^ xd ^ d,
                xa ^ a ^ xb ^ c ^ d,
                a ^ xb ^ b ^ xc ^ d,
                a ^ b ^ xc ^ c ^ xd};
    endfunction

endpackage

// ===== hdl/snow3g_step_unit.sv =====
module snow3g_step_unit (
    input  snow3g_pkg::cipher_state_t cur,
    input  logic                      feed_fsm,
    output snow3g_pkg::cipher_state_t nxt,
    output logic [31:0]               z
);
    import snow3g_pkg::*;

    logic [31:0] f;
    logic [31:0] r_new;
    logic [31:0] s1_out;
    logic [31:0] s2_out;
    logic [31:0] fb;

    always_comb begin
        f      = (cur.lfsr[15] + cur.r1) ^ cur.r2;
        r_new  = cur.r2 + (cur.r3 ^ cur.lfsr[5]);
        s1_out = mix_column(SBOX_R[cur.r1[31:24]], SBOX_R[cur.r1[23:16]],
                            SBOX_R[cur.r1[15:8]], SBOX_R[cur.r1[7:0]], POLY_S1);
        s2_out = mix_column(SBOX_Q[cur.r2[31:24]], SBOX_Q[cur.r2[23:16]],
                            SBOX_Q[cur.r2[15:8]], SBOX_Q[cur.r2[7:0]], POLY_S2);
        fb     = {cur.lfsr[0][23:0], 8'h00} ^ mul_alpha(cur.lfsr[0][31:24]) ^ cur.lfsr[2] ^
                 {8'h00, cur.lfsr[11][31:8]} ^ div_alpha(cur.lfsr[11][7:0]) ^
                 (feed_fsm ? f : 32'h0);

        nxt.lfsr = {fb, cur.lfsr[15:1]};
        nxt.r1   = r_new;
        nxt.r2   = s1_out;
        nxt.r3   = s2_out;
        z        = f ^ cur.lfsr[0];
    end

endmodule

// ===== hdl/snow3g_seq.sv =====
module snow3g_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [snow3g_pkg::WC_W-1:0]   s_word_count,
    input  logic                          out_free,
    output snow3g_pkg::ctrl_t             ctrl
);
    import snow3g_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_DISC = 2'd2;
    localparam logic [1:0] ST_GEN  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] burst;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign burst   = (s_word_count > WC_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                       : CNT_W'(s_word_count);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_INIT) begin
                        ctrl.load_init = 1'b1;
                        cnt_next       = CNT_W'(INIT_ROUNDS - 1);
                        state_next     = ST_INIT;
                    end else begin
                        cnt_next   = burst;
                        state_next = ST_DISC;
                    end
                end
            end
            ST_INIT: begin
                ctrl.step     = 1'b1;
                ctrl.feed_fsm = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DISC: begin
                // a step whose keystream output is dropped
                ctrl.step  = 1'b1;
                state_next = (cnt_reg == '0) ? ST_IDLE : ST_GEN;
            end
            ST_GEN: begin
                // advance only when the output register can take the word
                if (out_free) begin
                    ctrl.step = 1'b1;
                    ctrl.emit = 1'b1;
                    ctrl.last = (cnt_reg == CNT_W'(1));
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/snow3g_keystream_generator_core.sv =====
// SNOW 3G keystream generator. Write the 128-bit key through the register port
// (key_high at 0x0, key_low at 0x8) before sending an initialize transaction
// (mode 0) that carries the IV; it loads the LFSR and runs the 32 initialization
// steps, producing no output. A generate transaction (mode 1) runs one step whose
// output is dropped and then delivers word_count keystream words (saturated at
// 64), one per cycle while m_ready stays high, the final word flagged by
// m_last_word. One shared cipher-clock unit (FSM update and LFSR feedback) does
// one step per cycle unless the output register is full, so s_ready is low
// until the current transaction's steps are done. State resets to zero.
module snow3g_keystream_generator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [63:0]                 s_iv_high,
    input  logic [63:0]                 s_iv_low,
    input  logic [snow3g_pkg::WC_W-1:0] s_word_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [31:0]                 m_keystream_word,
    output logic                        m_last_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import snow3g_pkg::*;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    logic [63:0]   key_high_reg;
    logic [63:0]   key_low_reg;
    cipher_state_t st_reg;
    cipher_state_t st_next;
    cipher_state_t st_load;
    cipher_state_t st_step;
    logic [31:0]   z;
    ctrl_t         ctrl;
    logic          out_free;
    logic          m_valid_reg;
    logic [31:0]   m_word_reg;
    logic          m_last_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3])
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (wr_en) begin
            if (paddr[3] == REG_KEY_HIGH) begin
                key_high_reg <= pwdata;
            end else begin
                key_low_reg <= pwdata;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    snow3g_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_word_count (s_word_count),
        .out_free     (out_free),
        .ctrl         (ctrl)
    );

    snow3g_step_unit u_step (
        .cur      (st_reg),
        .feed_fsm (ctrl.feed_fsm),
        .nxt      (st_step),
        .z        (z)
    );

    // Key and IV placement into the LFSR cells; FSM starts cleared
    always_comb begin
        st_load.lfsr[15] = key_low_reg[31:0]   ^ s_iv_high[63:32];
        st_load.lfsr[14] = key_low_reg[63:32];
        st_load.lfsr[13] = key_high_reg[31:0];
        st_load.lfsr[12] = key_high_reg[63:32] ^ s_iv_high[31:0];
        st_load.lfsr[11] = ~key_low_reg[31:0];
        st_load.lfsr[10] = ~key_low_reg[63:32] ^ s_iv_low[63:32];
        st_load.lfsr[9]  = ~key_high_reg[31:0] ^ s_iv_low[31:0];
        st_load.lfsr[8]  = ~key_high_reg[63:32];
        st_load.lfsr[7]  = key_low_reg[31:0];
        st_load.lfsr[6]  = key_low_reg[63:32];
        st_load.lfsr[5]  = key_high_reg[31:0];
        st_load.lfsr[4]  = key_high_reg[63:32];
        st_load.lfsr[3]  = ~key_low_reg[31:0];
        st_load.lfsr[2]  = ~key_low_reg[63:32];
        st_load.lfsr[1]  = ~key_high_reg[31:0];
        st_load.lfsr[0]  = ~key_high_reg[63:32];
        st_load.r1       = '0;
        st_load.r2       = '0;
        st_load.r3       = '0;
    end

    always_comb begin
        st_next = st_reg;
        if (ctrl.load_init) begin
            st_next = st_load;
        end else if (ctrl.step) begin
            st_next = st_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_word_reg <= z;
            m_last_reg <= ctrl.last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_keystream_word = m_word_reg;
    assign m_last_word      = m_last_reg;

endmodule
